// File: design/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared widths, codes and types of the pairwise spin energy block.
// ----------------------------------------------------------------------------
package pse_pkg;

  // Site count default and register reset value
  localparam int unsigned MaxSitesDefault = 64;
  localparam int unsigned CfgW            = 7;
  localparam logic [CfgW-1:0] ActiveSitesReset = 7'd64;

  // Fixed payload widths
  localparam int unsigned IdxW    = 11;
  localparam int unsigned ValW    = 32;
  localparam int unsigned SpinW   = 64;
  localparam int unsigned SiteW   = 6;
  localparam int unsigned EnergyW = 48;

  // Configuration port
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;
  localparam logic        REG_ACTIVE_SITES = 1'b0;

  // Command queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_LOAD_FIELD = 2'd0,
    OP_LOAD_PAIR  = 2'd1,
    OP_TOTAL      = 2'd2,
    OP_DELTA      = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_LOAD_FIELD,
    CMD_LOAD_PAIR,
    CMD_TOTAL,
    CMD_DELTA,
    CMD_DELTA_NULL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [IdxW-1:0]   idx;
    logic [ValW-1:0]   value;
    logic [SpinW-1:0]  spins;
    logic [SiteW-1:0]  site;
    logic              up;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIELD,
    ST_PAIR,
    ST_DFLD,
    ST_DWALK,
    ST_DONE
  } back_state_e;

endpackage

// File: design/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front
// Accepts input items, sorts them into commands and drops loads that fall
// outside the tables.
// ----------------------------------------------------------------------------
module pse_front #(
  parameter int unsigned MaxSites = pse_pkg::MaxSitesDefault,
  localparam int unsigned CntW     = $clog2(MaxSites + 1)
) (
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [pse_pkg::IdxW-1:0]      table_index_i,
  input  logic [pse_pkg::ValW-1:0]      table_value_i,
  input  logic [pse_pkg::SpinW-1:0]     spins_i,
  input  logic [pse_pkg::SiteW-1:0]     flip_site_i,
  input  logic                          new_value_i,
  input  logic [CntW-1:0]               n_sites_i,
  input  pse_pkg::queue_status_t        q_status_i,
  output logic                          push_o,
  output pse_pkg::cmd_t                 push_data_o
);

  localparam int unsigned PairDepth = MaxSites * (MaxSites - 1) / 2;

  logic accept;
  logic keep;

  // Hold off new items while the queue is full
  assign busy   = q_status_i.full;
  assign accept = start && !q_status_i.full;

  // Classify the item
  always_comb begin
    keep                    = 1'b1;
    push_data_o.kind        = pse_pkg::CMD_TOTAL;
    push_data_o.idx         = table_index_i;
    push_data_o.value       = table_value_i;
    push_data_o.spins       = spins_i;
    push_data_o.site        = flip_site_i;
    push_data_o.up          = new_value_i;
    unique case (pse_pkg::opcode_e'(opcode_i))
      pse_pkg::OP_LOAD_FIELD: begin
        push_data_o.kind = pse_pkg::CMD_LOAD_FIELD;
        keep             = (32'(table_index_i) < 32'(MaxSites));
      end
      pse_pkg::OP_LOAD_PAIR: begin
        push_data_o.kind = pse_pkg::CMD_LOAD_PAIR;
        keep             = (32'(table_index_i) < 32'(PairDepth));
      end
      pse_pkg::OP_TOTAL: begin
        push_data_o.kind = pse_pkg::CMD_TOTAL;
      end
      pse_pkg::OP_DELTA: begin
        // A site beyond the active count gives a zero change
        if (32'(flip_site_i) >= 32'(n_sites_i)) begin
          push_data_o.kind = pse_pkg::CMD_DELTA_NULL;
        end else begin
          push_data_o.kind = pse_pkg::CMD_DELTA;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept && keep;

endmodule

// File: design/pse_queue.sv
// ----------------------------------------------------------------------------
// pse_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pse_queue #(
  parameter int unsigned Depth = pse_pkg::QueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pse_pkg::cmd_t          push_data_i,
  input  logic                   pop_i,
  output pse_pkg::cmd_t          head_o,
  output pse_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pse_pkg::cmd_t       entry_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(Depth));
  assign head_o         = entry_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

endmodule

// File: design/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back
// Carries out commands: writes the field and coupling memories and walks
// them one entry a cycle to accumulate energies.
// ----------------------------------------------------------------------------
module pse_back #(
  parameter int unsigned MaxSites = pse_pkg::MaxSitesDefault,
  localparam int unsigned CntW     = $clog2(MaxSites + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [CntW-1:0]               n_sites_i,
  input  pse_pkg::queue_status_t        q_status_i,
  input  pse_pkg::cmd_t                 head_i,
  output logic                          pop_o,
  output logic                          result_valid_o,
  output logic [pse_pkg::EnergyW-1:0]   energy_o,
  output logic                          is_delta_o
);

  localparam int unsigned PairDepth = MaxSites * (MaxSites - 1) / 2;
  localparam int unsigned SiteAw    = $clog2(MaxSites);
  localparam int unsigned PairAw    = (PairDepth > 1) ? $clog2(PairDepth) : 1;
  localparam int unsigned SiteW     = pse_pkg::SiteW;
  localparam int unsigned ValW      = pse_pkg::ValW;
  localparam int unsigned EnergyW   = pse_pkg::EnergyW;

  pse_pkg::back_state_e state_q, state_d;

  // Walk counters: k is the row or walked site, j the column, p the pair address
  logic [CntW-1:0]          k_q, k_d;
  logic [CntW-1:0]          j_q, j_d;
  logic [PairAw-1:0]        p_q, p_d;

  // Latched command
  logic [pse_pkg::SpinW-1:0] spins_q;
  logic [SiteW-1:0]          site_q;
  logic                      sub_q;
  logic                      delta_q;
  logic                      latch;

  // Read pipeline and accumulator
  logic                 rd_q, rd_d;
  logic                 use_q, use_d;
  logic                 from_pair_q, from_pair_d;
  logic [EnergyW-1:0]   acc_q, acc_d;
  logic                 res_d;
  logic                 res_vld_q;
  logic [EnergyW-1:0]   energy_q;
  logic                 is_delta_q;

  // Memories
  logic [ValW-1:0]      fld_mem  [MaxSites];
  logic [ValW-1:0]      pair_mem [PairDepth];
  logic [ValW-1:0]      fld_rdata_q;
  logic [ValW-1:0]      pair_rdata_q;
  logic                 fld_we, fld_re, pair_we, pair_re;
  logic [SiteAw-1:0]    fld_addr;
  logic [PairAw-1:0]    pair_addr;

  logic [SiteW:0]       k_ext, j_ext;
  logic                 spin_k, spin_j;
  logic [CntW-1:0]      n_m1, n_m2;
  logic [ValW-1:0]      add_val;
  logic [EnergyW-1:0]   addend, acc_sum;

  assign k_ext  = (SiteW + 1)'(k_q);
  assign j_ext  = (SiteW + 1)'(j_q);
  assign spin_k = spins_q[k_ext[SiteW-1:0]];
  assign spin_j = spins_q[j_ext[SiteW-1:0]];
  assign n_m1   = n_sites_i - CntW'(1);
  assign n_m2   = n_sites_i - CntW'(2);

  // Sequence the walks
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    j_d         = j_q;
    p_d         = p_q;
    pop_o       = 1'b0;
    latch       = 1'b0;
    fld_we      = 1'b0;
    fld_re      = 1'b0;
    pair_we     = 1'b0;
    pair_re     = 1'b0;
    fld_addr    = k_q[SiteAw-1:0];
    pair_addr   = p_q;
    rd_d        = 1'b0;
    use_d       = 1'b0;
    from_pair_d = 1'b0;
    res_d       = 1'b0;
    unique case (state_q)
      pse_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          unique case (head_i.kind)
            pse_pkg::CMD_LOAD_FIELD: begin
              fld_we   = 1'b1;
              fld_addr = head_i.idx[SiteAw-1:0];
            end
            pse_pkg::CMD_LOAD_PAIR: begin
              pair_we   = 1'b1;
              pair_addr = head_i.idx[PairAw-1:0];
            end
            pse_pkg::CMD_TOTAL: begin
              latch   = 1'b1;
              k_d     = '0;
              j_d     = CntW'(1);
              p_d     = '0;
              state_d = (n_sites_i == '0) ? pse_pkg::ST_DONE : pse_pkg::ST_FIELD;
            end
            pse_pkg::CMD_DELTA: begin
              latch   = 1'b1;
              k_d     = '0;
              // Pair address of (0, m), one below zero when m is zero
              p_d     = PairAw'(head_i.site) - PairAw'(1);
              state_d = pse_pkg::ST_DFLD;
            end
            pse_pkg::CMD_DELTA_NULL: begin
              latch   = 1'b1;
              state_d = pse_pkg::ST_DONE;
            end
            default: begin
              state_d = pse_pkg::ST_IDLE;
            end
          endcase
        end
      end
      pse_pkg::ST_FIELD: begin
        fld_re = 1'b1;
        rd_d   = 1'b1;
        use_d  = spin_k;
        k_d    = k_q + CntW'(1);
        if (k_q == n_m1) begin
          k_d     = '0;
          state_d = (n_sites_i >= CntW'(2)) ? pse_pkg::ST_PAIR : pse_pkg::ST_DONE;
        end
      end
      pse_pkg::ST_PAIR: begin
        if ((j_q == k_q + CntW'(1)) && !spin_k) begin
          // Skip a row whose own site is clear
          p_d = p_q + PairAw'(n_m1 - k_q);
          k_d = k_q + CntW'(1);
          j_d = k_q + CntW'(2);
        end else begin
          pair_re     = 1'b1;
          rd_d        = 1'b1;
          use_d       = spin_k && spin_j;
          from_pair_d = 1'b1;
          p_d         = p_q + PairAw'(1);
          if (j_q == n_m1) begin
            k_d = k_q + CntW'(1);
            j_d = k_q + CntW'(2);
          end else begin
            j_d = j_q + CntW'(1);
          end
        end
        if ((k_q == n_m2) && (j_q == n_m1)) begin
          state_d = pse_pkg::ST_DONE;
        end
      end
      pse_pkg::ST_DFLD: begin
        fld_re   = 1'b1;
        fld_addr = site_q[SiteAw-1:0];
        rd_d     = 1'b1;
        use_d    = 1'b1;
        state_d  = (n_sites_i == CntW'(1)) ? pse_pkg::ST_DONE : pse_pkg::ST_DWALK;
      end
      pse_pkg::ST_DWALK: begin
        if (k_ext != {1'b0, site_q}) begin
          pair_re     = 1'b1;
          rd_d        = 1'b1;
          use_d       = spin_k;
          from_pair_d = 1'b1;
        end
        // Below the site, step down the column; from the site on, along its row
        if (k_ext < {1'b0, site_q}) begin
          p_d = p_q + PairAw'(n_m2 - k_q);
        end else begin
          p_d = p_q + PairAw'(1);
        end
        k_d = k_q + CntW'(1);
        if (k_q == n_m1) begin
          state_d = pse_pkg::ST_DONE;
        end
      end
      pse_pkg::ST_DONE: begin
        res_d   = 1'b1;
        state_d = pse_pkg::ST_IDLE;
      end
      default: begin
        state_d = pse_pkg::ST_IDLE;
      end
    endcase
  end

  // Accumulate the entry read last cycle
  assign add_val = from_pair_q ? pair_rdata_q : fld_rdata_q;
  assign addend  = {{(EnergyW - ValW){add_val[ValW-1]}}, add_val};
  assign acc_sum = sub_q ? (acc_q - addend) : (acc_q + addend);

  always_comb begin
    if (latch) begin
      acc_d = '0;
    end else if (rd_q && use_q) begin
      acc_d = acc_sum;
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pse_pkg::ST_IDLE;
      rd_q      <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_q      <= rd_d;
      res_vld_q <= res_d;
    end
  end

  // Hold walk counters, command fields and result
  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    j_q         <= j_d;
    p_q         <= p_d;
    use_q       <= use_d;
    from_pair_q <= from_pair_d;
    acc_q       <= acc_d;
    if (latch) begin
      spins_q <= head_i.spins;
      site_q  <= head_i.site;
      sub_q   <= (head_i.kind == pse_pkg::CMD_DELTA) && !head_i.up;
      delta_q <= (head_i.kind != pse_pkg::CMD_TOTAL);
    end
    if (res_d) begin
      energy_q   <= acc_d;
      is_delta_q <= delta_q;
    end
  end

  // Field memory
  always_ff @(posedge clk_i) begin
    if (fld_we) begin
      fld_mem[fld_addr] <= head_i.value;
    end
    if (fld_re) begin
      fld_rdata_q <= fld_mem[fld_addr];
    end
  end

  // Coupling memory
  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_addr] <= head_i.value;
    end
    if (pair_re) begin
      pair_rdata_q <= pair_mem[pair_addr];
    end
  end

  assign result_valid_o = res_vld_q;
  assign energy_o       = energy_q;
  assign is_delta_o     = is_delta_q;

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |=> !res_vld_q)
    else $error("result strobe longer than one cycle");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pse_pkg::ST_IDLE) |-> !rd_q)
    else $error("read still in flight in idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(state_q == pse_pkg::ST_DONE))
    else $error("result not preceded by walk end");

endmodule

// File: design/pairwise_spin_energy.sv
// ----------------------------------------------------------------------------
// pairwise_spin_energy
// Energy evaluator for a binary spin model with per-site fields and packed
// upper-triangle couplings.
//
//   channel   direction  handshake                      payload
//   command   in         start high, busy low           opcode_i, table_index_i,
//                                                        table_value_i, spins_i,
//                                                        flip_site_i, new_value_i
//   result    out        result_valid_o, one cycle       energy_o, is_delta_o
//   config    in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// In the back end, a query walks the tables, one coupling a cycle through the
// single coupling memory port; a total query passes over a row whose own
// site is clear without reading its couplings.
// Items wait in a two-entry queue; busy is high while it is full.
// The result strobe is registered from the done state that ends a walk; it cannot stall.
// Reset sets active_sites to 64; both tables hold nothing until loaded.
// ----------------------------------------------------------------------------
module pairwise_spin_energy #(
  parameter int unsigned MaxSites = pse_pkg::MaxSitesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode_i,
  input  logic [pse_pkg::IdxW-1:0]        table_index_i,
  input  logic signed [pse_pkg::ValW-1:0] table_value_i,
  input  logic [pse_pkg::SpinW-1:0]       spins_i,
  input  logic [pse_pkg::SiteW-1:0]       flip_site_i,
  input  logic                            new_value_i,
  output logic                            result_valid_o,
  output logic signed [pse_pkg::EnergyW-1:0] energy_o,
  output logic                            is_delta_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pse_pkg::PAddrW-1:0]      paddr,
  input  logic [pse_pkg::PDataW-1:0]      pwdata,
  output logic [pse_pkg::PDataW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned CntW = $clog2(MaxSites + 1);

  logic [pse_pkg::CfgW-1:0]    active_sites_q;
  logic [CntW-1:0]             n_sites;
  logic                        reg_sel;
  logic                        push;
  pse_pkg::cmd_t               push_data;
  pse_pkg::cmd_t               head;
  logic                        pop;
  pse_pkg::queue_status_t      q_status;
  logic [pse_pkg::EnergyW-1:0] energy;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == pse_pkg::REG_ACTIVE_SITES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_sites_q <= pse_pkg::ActiveSitesReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      active_sites_q <= pwdata[pse_pkg::CfgW-1:0];
    end
  end

  assign prdata = reg_sel ? pse_pkg::PDataW'(active_sites_q) : '0;

  // Clamp the site count to the table size
  assign n_sites = (32'(active_sites_q) > 32'(MaxSites)) ? CntW'(MaxSites)
                                                         : active_sites_q[CntW-1:0];

  pse_front #(
    .MaxSites (MaxSites)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .spins_i       (spins_i),
    .flip_site_i   (flip_site_i),
    .new_value_i   (new_value_i),
    .n_sites_i     (n_sites),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  pse_queue #(
    .Depth (pse_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  pse_back #(
    .MaxSites (MaxSites)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .n_sites_i      (n_sites),
    .q_status_i     (q_status),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .energy_o       (energy),
    .is_delta_o     (is_delta_o)
  );

  assign energy_o = energy;

endmodule

// File: dv/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Watches the command, result and register channels of pairwise_spin_energy.
// It keeps its own copy of the field and coupling tables and the site count,
// works out the energy each accepted query must give, and compares every
// result strobe with the oldest outstanding energy. It hands a failure count
// and the number of outstanding energies to the testbench top.
// ----------------------------------------------------------------------------
module pse_checker
  import pse_pkg::*;
#(
  parameter int unsigned MaxSites = MaxSitesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [1:0]                opcode_i,
  input  logic [IdxW-1:0]           table_index_i,
  input  logic signed [ValW-1:0]    table_value_i,
  input  logic [SpinW-1:0]          spins_i,
  input  logic [SiteW-1:0]          flip_site_i,
  input  logic                      new_value_i,
  input  logic                      result_valid_i,
  input  logic signed [EnergyW-1:0] energy_i,
  input  logic                      is_delta_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [PAddrW-1:0]         paddr_i,
  input  logic [PDataW-1:0]         pwdata_i,
  input  logic [PDataW-1:0]         prdata_i,
  input  logic                      pready_i,
  output int                        fails_o,
  output int                        awaiting_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PairSlots = MaxSites * (MaxSites - 1) / 2;
  localparam logic [PAddrW-1:0] SitesAddr = PAddrW'(4 * REG_ACTIVE_SITES);

  typedef struct packed {
    logic signed [EnergyW-1:0] energy;
    logic                      is_delta;
  } energy_result_t;

  // Shadow state of the block
  logic signed [ValW-1:0] field_mem    [MaxSites];
  logic signed [ValW-1:0] coupling_mem [PairSlots];
  logic [CfgW-1:0]        sites_cfg = ActiveSitesReset;

  energy_result_t expected_energy_q [$];
  energy_result_t oldest;

  initial begin
    fails_o    = 0;
    awaiting_o = 0;
  end

  // Site count in use: anything above the table size acts as the table size
  function automatic int sites_in_use();
    return (sites_cfg > MaxSites) ? MaxSites : int'(sites_cfg);
  endfunction

  // Packed upper-triangle slot of pair (i, j), i < j < n
  function automatic int pair_slot(int n, int i, int j);
    return (n - 1) * i - i * (i + 1) / 2 + j - 1;
  endfunction

  // Sum of fields of set sites plus couplings of set pairs
  function automatic logic signed [EnergyW-1:0] total_energy_of(logic [SpinW-1:0] pattern,
                                                                int n);
    longint acc;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      if (pattern[i]) acc += longint'(field_mem[i]);
    end
    for (int i = 0; i < n - 1; i++) begin
      if (pattern[i]) begin
        for (int j = i + 1; j < n; j++) begin
          if (pattern[j]) acc += longint'(coupling_mem[pair_slot(n, i, j)]);
        end
      end
    end
    return acc[EnergyW-1:0];
  endfunction

  // Field of the flipped site plus its couplings to the other set sites, negated for a flip down
  function automatic logic signed [EnergyW-1:0] flip_delta_of(logic [SpinW-1:0] pattern,
                                                              int n, int m, logic up);
    longint acc;
    if (m >= n) return '0;
    acc = longint'(field_mem[m]);
    for (int k = 0; k < m; k++) begin
      if (pattern[k]) acc += longint'(coupling_mem[pair_slot(n, k, m)]);
    end
    for (int k = m + 1; k < n; k++) begin
      if (pattern[k]) acc += longint'(coupling_mem[pair_slot(n, m, k)]);
    end
    if (!up) acc = -acc;
    return acc[EnergyW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sites_cfg = ActiveSitesReset;
      expected_energy_q.delete();
    end else begin
      // Compare the result strobe against the oldest outstanding energy
      if (result_valid_i) begin
        if (expected_energy_q.size() == 0) begin
          $error("result with nothing outstanding: energy %0d, is_delta %0b",
                 energy_i, is_delta_i);
          fails_o++;
        end else begin
          oldest = expected_energy_q.pop_front();
          if (energy_i !== oldest.energy) begin
            $error("energy: expected %0d, actual %0d", oldest.energy, energy_i);
            fails_o++;
          end
          if (is_delta_i !== oldest.is_delta) begin
            $error("is_delta: expected %0b, actual %0b", oldest.is_delta, is_delta_i);
            fails_o++;
          end
        end
      end

      // Track register writes and check read-back
      if (psel_i && penable_i && pready_i && paddr_i == SitesAddr) begin
        if (pwrite_i) begin
          sites_cfg = pwdata_i[CfgW-1:0];
        end else if (prdata_i !== PDataW'(sites_cfg)) begin
          $error("prdata: expected %0d, actual %0d", sites_cfg, prdata_i);
          fails_o++;
        end
      end

      // Apply accepted command transfers to the shadow state
      if (start_i && !busy_i) begin
        case (opcode_i)
          OP_LOAD_FIELD: begin
            if (table_index_i < MaxSites) field_mem[table_index_i] = table_value_i;
          end
          OP_LOAD_PAIR: begin
            if (table_index_i < PairSlots) coupling_mem[table_index_i] = table_value_i;
          end
          OP_TOTAL: begin
            expected_energy_q.push_back('{total_energy_of(spins_i, sites_in_use()), 1'b0});
          end
          default: begin
            expected_energy_q.push_back('{flip_delta_of(spins_i, sites_in_use(),
                                                         int'(flip_site_i), new_value_i),
                                          1'b1});
          end
        endcase
      end
    end
    awaiting_o = expected_energy_q.size();
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression top for pairwise_spin_energy. Fills both tables at full scale,
// checks full-scale sums of either sign, runs a short directed set at the
// reset site count, then random phases over a range of site counts from 0
// to 127. The command sender works in random bursts and gaps; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  localparam int unsigned PairSlots     = MaxSitesDefault * (MaxSitesDefault - 1) / 2;
  localparam logic [PAddrW-1:0] SitesAddr = PAddrW'(4 * REG_ACTIVE_SITES);
  localparam int          WatchdogLimit = 20000;
  localparam int          ConfigQuiet   = 16;
  localparam int          EndQuiet      = 256;
  localparam int          SmallCount    = 30;
  localparam int          LargeCount    = 10;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      start        = 1'b0;
  logic                      busy;
  logic [1:0]                opcode       = OP_LOAD_FIELD;
  logic [IdxW-1:0]           table_index  = '0;
  logic signed [ValW-1:0]    table_value  = '0;
  logic [SpinW-1:0]          spins        = '0;
  logic [SiteW-1:0]          flip_site    = '0;
  logic                      new_value    = 1'b0;
  logic                      result_valid;
  logic signed [EnergyW-1:0] energy;
  logic                      is_delta;
  logic                      psel         = 1'b0;
  logic                      penable      = 1'b0;
  logic                      pwrite       = 1'b0;
  logic [PAddrW-1:0]         paddr        = '0;
  logic [PDataW-1:0]         pwdata       = '0;
  logic [PDataW-1:0]         prdata;
  logic                      pready;

  int check_fails;
  int awaiting;
  int burst_left   = 0;
  int items_sent   = 0;
  int queries_sent = 0;
  int phases_run   = 0;
  int quiet_cycles = 0;

  logic [CfgW-1:0] site_plan [17] = '{7'd2, 7'd0, 7'd1, 7'd127, 7'd3, 7'd4, 7'd5, 7'd65,
                                      7'd7, 7'd8, 7'd12, 7'd16, 7'd20, 7'd31, 7'd32,
                                      7'd40, 7'd64};

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pairwise_spin_energy i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode),
    .table_index_i  (table_index),
    .table_value_i  (table_value),
    .spins_i        (spins),
    .flip_site_i    (flip_site),
    .new_value_i    (new_value),
    .result_valid_o (result_valid),
    .energy_o       (energy),
    .is_delta_o     (is_delta),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  pse_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .opcode_i       (opcode),
    .table_index_i  (table_index),
    .table_value_i  (table_value),
    .spins_i        (spins),
    .flip_site_i    (flip_site),
    .new_value_i    (new_value),
    .result_valid_i (result_valid),
    .energy_i       (energy),
    .is_delta_i     (is_delta),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .fails_o        (check_fails),
    .awaiting_o     (awaiting)
  );

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("pairwise_spin_energy regression: fail");
        $finish;
      end
    end
  end

  // Table value biased towards the Q16.16 extremes and small numbers
  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return ValW'($urandom_range(0, 511)) - ValW'(256);
      default: return ValW'($urandom());
    endcase
  endfunction

  // Spin pattern: dense, sparse, single-bit, all or none, or plain random
  function automatic logic [SpinW-1:0] pick_spins();
    logic [SpinW-1:0] a;
    logic [SpinW-1:0] b;
    logic [SpinW-1:0] c;
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    c = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return a & b & c;
      3:       return a | b | c;
      4:       return SpinW'(1) << $urandom_range(0, SpinW - 1);
      default: return a;
    endcase
  endfunction

  // Drive one command transfer; open a gap first when the burst is spent
  task automatic issue(input opcode_e op, input logic [IdxW-1:0] idx,
                       input logic [ValW-1:0] val, input logic [SpinW-1:0] pattern,
                       input logic [SiteW-1:0] site, input logic up);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    opcode      <= op;
    table_index <= idx;
    table_value <= val;
    spins       <= pattern;
    flip_site   <= site;
    new_value   <= up;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy);
    burst_left--;
    items_sent++;
    if (op == OP_TOTAL || op == OP_DELTA) queries_sent++;
  endtask

  // Drop start, wait for every outstanding result, then hold quiet
  task automatic drain(input int hold);
    start <= 1'b0;
    @(posedge clk_i);
    wait (awaiting == 0);
    repeat (hold) @(posedge clk_i);
  endtask

  task automatic write_sites(input logic [CfgW-1:0] value);
    logic [PDataW-1:0] noise;
    noise = $urandom();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SitesAddr;
    pwdata  <= {noise[PDataW-1:CfgW], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_sites();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SitesAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load every table entry with one level, or with random values when scattered
  task automatic fill_tables(input logic [ValW-1:0] level, input bit scatter);
    for (int k = 0; k < MaxSitesDefault; k++) begin
      issue(OP_LOAD_FIELD, IdxW'(k), scatter ? pick_value() : level, pick_spins(),
            SiteW'($urandom()), 1'($urandom()));
    end
    for (int p = 0; p < PairSlots; p++) begin
      issue(OP_LOAD_PAIR, IdxW'(p), scatter ? pick_value() : level, pick_spins(),
            SiteW'($urandom()), 1'($urandom()));
    end
  endtask

  // Queries that reach the largest sums with all sites set, and one delta over alternate sites
  task automatic extreme_queries();
    issue(OP_TOTAL, IdxW'($urandom()), $urandom(), '1, SiteW'($urandom()), 1'($urandom()));
    issue(OP_DELTA, IdxW'($urandom()), $urandom(), '1, 6'd63, 1'b1);
    issue(OP_DELTA, IdxW'($urandom()), $urandom(), '1, 6'd0, 1'b0);
    issue(OP_DELTA, IdxW'($urandom()), $urandom(), 64'h5555_5555_5555_5555, 6'd32, 1'b1);
  endtask

  // One random phase at a given site-count setting
  task automatic run_phase(input logic [CfgW-1:0] setting, input int count);
    int n;
    int pairs;
    int pick;
    logic [IdxW-1:0]  idx;
    logic [SiteW-1:0] site;
    drain(ConfigQuiet);
    write_sites(setting);
    read_sites();
    phases_run++;
    n     = (setting > MaxSitesDefault) ? MaxSitesDefault : int'(setting);
    pairs = (n > 1) ? n * (n - 1) / 2 : 0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      site = (n > 0 && $urandom_range(0, 4) != 0) ? SiteW'($urandom_range(0, n - 1))
                                                  : SiteW'($urandom());
      if (pick < 12) begin
        issue(OP_LOAD_FIELD, IdxW'($urandom_range(0, MaxSitesDefault - 1)), pick_value(),
              pick_spins(), site, 1'($urandom()));
      end else if (pick < 24) begin
        idx = (pairs > 0 && $urandom_range(0, 1) == 0) ? IdxW'($urandom_range(0, pairs - 1))
                                                       : IdxW'($urandom_range(0, PairSlots - 1));
        issue(OP_LOAD_PAIR, idx, pick_value(), pick_spins(), site, 1'($urandom()));
      end else if (pick < 28) begin
        // Loads beyond the tables must leave them untouched
        if ($urandom_range(0, 1) == 0) begin
          issue(OP_LOAD_FIELD, IdxW'($urandom_range(MaxSitesDefault, 2047)), pick_value(),
                pick_spins(), site, 1'($urandom()));
        end else begin
          issue(OP_LOAD_PAIR, IdxW'($urandom_range(PairSlots, 2047)), pick_value(),
                pick_spins(), site, 1'($urandom()));
        end
      end else if (pick < 62) begin
        issue(OP_TOTAL, IdxW'($urandom()), $urandom(), pick_spins(), site, 1'($urandom()));
      end else begin
        issue(OP_DELTA, IdxW'($urandom()), $urandom(), pick_spins(), site, 1'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] setting;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-scale tables, then the largest sums of either sign
    fill_tables(32'h7FFF_FFFF, 1'b0);
    extreme_queries();

    // Directed set at the reset site count
    issue(OP_LOAD_FIELD, IdxW'(MaxSitesDefault), 32'h1234_5678, '0, '0, 1'b0);
    issue(OP_LOAD_FIELD, '1, 32'h8765_4321, '1, '1, 1'b1);
    issue(OP_LOAD_PAIR, IdxW'(PairSlots), 32'h0BAD_F00D, '0, '0, 1'b0);
    issue(OP_LOAD_PAIR, '1, 32'hF00D_0BAD, '1, '1, 1'b1);
    issue(OP_TOTAL, '0, '0, '0, '0, 1'b0);
    issue(OP_TOTAL, '1, '1, '1, '1, 1'b1);
    issue(OP_TOTAL, '0, '0, 64'h5555_5555_5555_5555, '0, 1'b0);
    issue(OP_TOTAL, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0);
    issue(OP_TOTAL, '0, '0, 64'h1, '0, 1'b0);
    issue(OP_TOTAL, '0, '0, 64'h8000_0000_0000_0000, '0, 1'b0);
    issue(OP_DELTA, '0, '0, '1, 6'd0, 1'b1);
    issue(OP_DELTA, '0, '0, '0, 6'd0, 1'b0);
    // Own bit of the flipped site alone, then with every other site
    issue(OP_DELTA, '0, '0, 64'h8000_0000_0000_0000, 6'd63, 1'b1);
    issue(OP_DELTA, '0, '0, '1, 6'd63, 1'b0);
    issue(OP_DELTA, '0, '0, pick_spins(), 6'd17, 1'b1);
    issue(OP_DELTA, '0, '0, pick_spins(), 6'd40, 1'b0);
    issue(OP_LOAD_FIELD, IdxW'(5), '0, '0, '0, 1'b0);
    issue(OP_LOAD_PAIR, '0, '1, '0, '0, 1'b0);
    issue(OP_LOAD_FIELD, IdxW'(63), 32'h7FFF_FFFF, '0, '0, 1'b0);
    issue(OP_TOTAL, '0, '0, '1, '0, 1'b0);
    issue(OP_DELTA, '0, '0, '1, 6'd5, 1'b1);

    // Random phases over fixed and random site counts
    foreach (site_plan[i]) begin
      setting = site_plan[i];
      run_phase(setting, (setting >= 32) ? LargeCount : SmallCount);
    end
    repeat (3) begin
      setting = CfgW'($urandom_range(2, 24));
      run_phase(setting, SmallCount);
    end

    drain(EndQuiet);
    $display("covered %0d commands (%0d queries) over %0d register phases,",
             items_sent, queries_sent, phases_run);
    $display("site counts 0 to 127 with full-scale tables, random loads and ignored loads");
    if (check_fails == 0) begin
      $display("pairwise_spin_energy regression: pass");
    end else begin
      $display("pairwise_spin_energy regression: fail");
    end
    $finish;
  end

endmodule
